// File: rtl/ffa_pkg.sv
// ffa_pkg: shared types and codes for the first-fit allocator
// opcode and status codes, controller states, byte-chain control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  // operation codes on the input beat
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_DEFRAG = 2'd2;
  // spare code, decoded as defragment
  localparam logic [1:0] OP_RSVD   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_ERASED  = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_DEFRAG  = 3'd4;

  // bit width of the stream words
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_W       = 8;
  localparam logic [CFG_W-1:0] TOTAL_SIZE_RST = 8'd128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_ERASE,
    S_DEFRAG,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_ROTATE,
    MODE_SWAP
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t mode;
    logic        phase;  // odd-even transposition phase
  } chain_ctl_t;

endpackage

`default_nettype wire

// File: rtl/first_fit_allocator_with_compaction.sv
// first_fit_allocator_with_compaction: top level, controller and output register
// drives the byte chain through at most two passes per operation
// depends on ffa_pkg, ffa_chain
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: opcode[1:0], operand[9:2]
//  m_*     | out | m_tvalid/m_tready  | m_tdata: status[2:0], block_id[10:3]
//  cfg_*   | in  | cfg_we             | cfg_wdata: total_size
//
// alloc that fits: find pass then claim pass; alloc with no fit, erase and defragment:
// one pass; zero-size alloc, exhausted ids and erase ids of zero or above the last issued
// go straight to the finish state. the chain moves one cell a cycle. reset clears the owner
// store at once, no sweep. a new beat is taken only in idle; a finished result waits in the
// finish state while the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_allocator_with_compaction import ffa_pkg::*; #(
  parameter int MEM_BYTES = 128,
  parameter int ID_BITS   = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // opcode[1:0], operand[9:2]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // status[2:0], block_id[10:3]
  input  wire logic                   cfg_we,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  localparam int CW   = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int RW   = $clog2(MEM_BYTES + 1);
  localparam int MW   = (RW > ID_BITS) ? RW : ID_BITS;
  localparam int CMPW = ((MW > 8) ? MW : 8) + 2;
  localparam logic [CW-1:0]      LAST   = CW'(MEM_BYTES - 1);
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  ctrl_state_t       state, state_next;
  logic [CW-1:0]     cnt;
  logic [1:0]        op;
  logic [7:0]        arg;
  logic [RW-1:0]     run;
  logic [CW-1:0]     start;
  logic              found;
  logic [7:0]        rem;
  logic [ID_BITS-1:0] next_id;
  logic [CFG_W-1:0]  total_size;
  logic [2:0]        res_status;
  logic [7:0]        res_id;

  chain_ctl_t        ctl;
  logic [ID_BITS-1:0] tail;
  logic [ID_BITS-1:0] head;

  logic              in_beat;
  logic              last_cnt;
  logic              in_span;
  logic              head_free;
  logic              hit;
  logic              match;
  logic              in_block;
  logic              load_out;
  logic [ID_BITS-1:0] new_id;
  logic [RW-1:0]     run_inc;
  logic [1:0]        in_op;
  logic [7:0]        in_arg;
  logic              early_null;
  logic              early_illegal;

  assign in_op    = s_tdata[1:0];
  assign in_arg   = s_tdata[9:2];
  assign in_beat  = s_tvalid && s_tready;
  assign last_cnt = (cnt == LAST);
  assign new_id   = next_id + 1'b1;
  assign run_inc  = run + 1'b1;

  assign in_span   = CMPW'(cnt) < CMPW'(total_size);
  assign head_free = (head == '0) && in_span;
  assign hit       = !found && head_free && (CMPW'(run_inc) == CMPW'(arg));
  assign match     = CMPW'(head) == CMPW'(arg);
  assign in_block  = (cnt >= start) && (rem != 8'd0);

  assign early_null    = (in_arg == 8'd0) || (next_id == ID_MAX);
  assign early_illegal = (in_arg == 8'd0) || (CMPW'(in_arg) > CMPW'(next_id));

  ffa_chain #(
    .N (MEM_BYTES),
    .W (ID_BITS)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .tail (tail),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl.mode   = MODE_HOLD;
    ctl.phase  = cnt[0];
    tail       = head;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (in_beat) begin
          case (in_op)
            OP_ALLOC: state_next = early_null ? S_FINISH : S_SCAN;
            OP_ERASE: state_next = early_illegal ? S_FINISH : S_ERASE;
            default:  state_next = S_DEFRAG;
          endcase
        end
      end
      S_SCAN: begin
        ctl.mode = MODE_ROTATE;
        if (last_cnt) begin
          state_next = (found || hit) ? S_WRITE : S_FINISH;
        end
      end
      S_WRITE: begin
        ctl.mode = MODE_ROTATE;
        tail     = in_block ? new_id : head;
        if (last_cnt) begin
          state_next = S_FINISH;
        end
      end
      S_ERASE: begin
        ctl.mode = MODE_ROTATE;
        tail     = match ? '0 : head;
        if (last_cnt) begin
          state_next = S_FINISH;
        end
      end
      S_DEFRAG: begin
        ctl.mode = MODE_SWAP;
        if (last_cnt) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pass counter and per-operation working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      next_id <= '0;
      found   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt   <= '0;
          found <= 1'b0;
        end
        S_SCAN: begin
          cnt <= last_cnt ? '0 : cnt + 1'b1;
          if (hit) begin
            found <= 1'b1;
          end
        end
        S_WRITE: begin
          cnt <= last_cnt ? '0 : cnt + 1'b1;
          if (last_cnt) begin
            next_id <= new_id;
          end
        end
        S_ERASE: begin
          cnt <= last_cnt ? '0 : cnt + 1'b1;
          if (match) begin
            found <= 1'b1;
          end
        end
        S_DEFRAG: begin
          cnt <= last_cnt ? '0 : cnt + 1'b1;
        end
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op  <= in_op;
        arg <= in_arg;
        run <= '0;
        res_id <= 8'd0;
        if (in_op == OP_ALLOC) begin
          res_status <= ST_NULL;
        end else if (in_op == OP_ERASE) begin
          res_status <= ST_ILLEGAL;
        end else begin
          res_status <= ST_DEFRAG;
        end
      end
      S_SCAN: begin
        if (!found) begin
          if (head_free) begin
            run <= run_inc;
            if (run == '0) begin
              start <= cnt;
            end
          end else begin
            run <= '0;
          end
        end
        rem <= arg;
      end
      S_WRITE: begin
        if (in_block) begin
          rem <= rem - 1'b1;
        end
        if (last_cnt) begin
          res_status <= ST_ALLOC;
          res_id     <= 8'(new_id);
        end
      end
      S_ERASE: begin
        if (last_cnt) begin
          res_status <= (found || match) ? ST_ERASED : ST_ILLEGAL;
        end
      end
      default: res_status <= res_status;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_size <= TOTAL_SIZE_RST;
    end else if (cfg_we) begin
      total_size <= cfg_wdata;
    end
  end

  // output register: holds one result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'd0, res_id, res_status};
    end
  end

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && last_cnt) |=> (next_id == $past(new_id)))
    else $error("block id did not advance by one after a claim");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status != ST_ALLOC) |-> (res_id == 8'd0))
    else $error("non-alloc result carries a block id");

  a_fit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (CMPW'(start) + CMPW'(arg) <= CMPW'(total_size)))
    else $error("claimed run runs past the span");

  a_erase_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE) |-> (op == OP_ERASE && arg != 8'd0))
    else $error("erase pass entered without a valid erase id");

endmodule

`default_nettype wire

// File: rtl/ffa_cell.sv
// ffa_cell: one byte of the owner store
// rotates toward the head or does an odd-even compare-exchange with a neighbor
// depends on ffa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffa_cell import ffa_pkg::*; #(
  parameter int W         = 8,
  parameter bit HAS_LEFT  = 1'b1,
  parameter bit HAS_RIGHT = 1'b1,
  parameter bit PAR       = 1'b0
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire chain_ctl_t   ctl,
  input  wire logic [W-1:0] left_val,
  input  wire logic [W-1:0] right_val,
  input  wire logic [W-1:0] shift_in,
  output logic      [W-1:0] val
);

  logic [W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctl.mode)
      MODE_ROTATE: val_next = shift_in;
      MODE_SWAP: begin
        // live bytes move down over free ones, order among live bytes kept
        if (HAS_RIGHT && (PAR == ctl.phase) && (val == '0) && (right_val != '0)) begin
          val_next = right_val;
        end else if (HAS_LEFT && (PAR != ctl.phase) && (left_val == '0) && (val != '0)) begin
          val_next = '0;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ffa_chain.sv
// ffa_chain: row of byte cells holding the owner id of every byte
// head is byte 0 in rotate mode; tail feeds the last cell
// depends on ffa_pkg, ffa_cell
`timescale 1ns / 1ps
`default_nettype none

module ffa_chain import ffa_pkg::*; #(
  parameter int N = 128,
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire chain_ctl_t   ctl,
  input  wire logic [W-1:0] tail,
  output logic      [W-1:0] head
);

  logic [W-1:0] owner [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left_v;
    logic [W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = owner[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_v = tail;
    end else begin : g_mid_r
      assign right_v = owner[i+1];
    end

    ffa_cell #(
      .W         (W),
      .HAS_LEFT  (i != 0),
      .HAS_RIGHT (i != N - 1),
      .PAR       (1'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .shift_in  (right_v),
      .val       (owner[i])
    );
  end

  assign head = owner[0];

endmodule

`default_nettype wire
